[sv/tdts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdts_pkg
// Shared types, codes and lookup functions of the token scanner.
// ----------------------------------------------------------------------------
package tdts_pkg;

    localparam int LINE_BITS = 16;
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    // byte classes
    localparam logic [2:0] CLS_WS     = 3'd0;
    localparam logic [2:0] CLS_QUOTE  = 3'd1;
    localparam logic [2:0] CLS_DIGIT  = 3'd2;
    localparam logic [2:0] CLS_LETTER = 3'd3;
    localparam logic [2:0] CLS_SYMBOL = 3'd4;
    localparam logic [2:0] CLS_ILLEGAL = 3'd5;

    // scanner states
    localparam logic [2:0] ST_START   = 3'd0;
    localparam logic [2:0] ST_T1      = 3'd1;
    localparam logic [2:0] ST_T2      = 3'd2;
    localparam logic [2:0] ST_T3      = 3'd3;
    localparam logic [2:0] ST_T2_DIG  = 3'd4;
    localparam logic [2:0] ST_NO_MOVE = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_EOF   = 2'd3;

    // token classes
    localparam logic [1:0] TOK_NONE = 2'd0;
    localparam logic [1:0] TOK_T1   = 2'd1;
    localparam logic [1:0] TOK_T2   = 2'd2;
    localparam logic [1:0] TOK_T3   = 2'd3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [1:0] REG_FIRST_LINE = 2'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  token_class;
        logic [7:0]  out_char;
        logic [15:0] line;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

    function automatic logic [2:0] class_of(input logic [7:0] c);
        logic [2:0] cls;
        if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
            cls = CLS_WS;
        end else if (c == CH_QUOTE || c == CH_HASH) begin
            cls = CLS_QUOTE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cls = CLS_DIGIT;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            cls = CLS_LETTER;
        end else if (c >= 8'h24 && c <= 8'h2F) begin
            cls = CLS_SYMBOL;
        end else begin
            cls = CLS_ILLEGAL;
        end
        return cls;
    endfunction

    function automatic logic [2:0] move(input logic [2:0] s, input logic [2:0] cls);
        logic [2:0] nxt;
        nxt = ST_NO_MOVE;
        case (s)
            ST_START: begin
                case (cls)
                    CLS_WS:     nxt = ST_START;
                    CLS_QUOTE:  nxt = ST_T1;
                    CLS_LETTER: nxt = ST_T2;
                    CLS_SYMBOL: nxt = ST_T3;
                    default:    nxt = ST_NO_MOVE;
                endcase
            end
            ST_T1: begin
                if (cls == CLS_DIGIT) nxt = ST_T1;
            end
            ST_T2: begin
                if (cls == CLS_DIGIT) nxt = ST_T2_DIG;
                else if (cls == CLS_LETTER) nxt = ST_T2;
            end
            ST_T2_DIG: begin
                if (cls == CLS_DIGIT) nxt = ST_T2_DIG;
            end
            default: nxt = ST_NO_MOVE;
        endcase
        return nxt;
    endfunction

    function automatic logic [1:0] class_of_state(input logic [2:0] s);
        logic [1:0] t;
        case (s)
            ST_T1:     t = TOK_T1;
            ST_T2:     t = TOK_T2;
            ST_T2_DIG: t = TOK_T2;
            ST_T3:     t = TOK_T3;
            default:   t = TOK_NONE;
        endcase
        return t;
    endfunction

    function automatic logic [LINE_BITS-1:0] clamp_line(input logic [15:0] v);
        logic [LINE_BITS-1:0] r;
        if (33'(v) > 33'(LINE_MAX)) r = LINE_MAX;
        else r = LINE_BITS'(v);
        return r;
    endfunction

endpackage

[sv/table_driven_token_scanner_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_token_scanner_core
// Byte-stream token scanner: classifies bytes, steps the token machine and
// streams token characters, token ends, errors and end of file.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: in_char; tuser: end_of_input
//  m_axis   | out | m_axis_tvalid/tready   | tdata: token_class, out_char, line;
//           |     |                        | tuser: kind; tlast: last
//  apb      | in  | psel/penable/pready    | first_line at byte address 0
//
// One byte is taken every cycle while the output does not stall; an item
// that makes two results (token end plus the next character, or token end
// plus end of file) is absorbed by the queue when it is empty after the
// pop, else the input waits.
// Results pass the input register, then the result queue.
// Reset is synchronous, active low; it empties both stages and loads the
// line counter from the reset value of first_line.
// A stalled output keeps up to two results and input keeps flowing until
// the queue cannot take the results of the waiting item.
// ----------------------------------------------------------------------------
module table_driven_token_scanner_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  logic        s_axis_tuser,   // [0] end_of_input
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [1:0] token_class, [9:2] out_char, [25:10] line
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tdts_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eoi_reg;
    logic [15:0] first_line_reg;

    logic        consume;
    logic        push_ok;
    logic        cfg_wr;
    step_out_t   step_out;
    result_t     out_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_FIRST_LINE[0]);
    assign prdata  = (paddr[2] == REG_FIRST_LINE[0]) ? {16'd0, first_line_reg} : 32'd0;

    assign consume       = in_valid_reg && push_ok;
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            first_line_reg <= 16'd1;
        end else begin
            if (cfg_wr) first_line_reg <= pwdata[15:0];
            if (s_axis_tvalid && s_axis_tready) in_valid_reg <= 1'b1;
            else if (consume) in_valid_reg <= 1'b0;
        end
    end

    // payload of an accepted transfer
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_char_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
    end

    tdts_scan u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (in_valid_reg),
        .consume         (consume),
        .in_char         (in_char_reg),
        .end_of_input    (in_eoi_reg),
        .line_load       (cfg_wr),
        .line_load_value (pwdata[15:0]),
        .step_out        (step_out)
    );

    tdts_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step_out),
        .push_ok   (push_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.line, out_res.out_char, out_res.token_class};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");

    a_consume_push: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |=> in_valid_reg && in_char_reg == $past(in_char_reg))
        else $error("waiting item lost");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
        else $error("stalled result transfer changed");

endmodule

[sv/tdts_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdts_scan
// Scanner state and the combinational step logic that turns an item into results.
// ----------------------------------------------------------------------------
module tdts_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    input  logic                            consume,
    input  logic [7:0]                      in_char,
    input  logic                            end_of_input,
    input  logic                            line_load,
    input  logic [15:0]                     line_load_value,
    output tdts_pkg::step_out_t             step_out
);
    import tdts_pkg::*;

    logic [2:0]           scan_state_reg, scan_state_next;
    logic                 in_comment_reg, in_comment_next;
    logic [LINE_BITS-1:0] line_count_reg, line_count_next;

    logic [2:0]           s;
    logic [2:0]           cls;
    logic [2:0]           nxt_tok;
    logic [2:0]           nxt_start;
    logic [LINE_BITS-1:0] line_inc;
    logic [15:0]          line_out;
    logic                 is_nl;
    logic                 is_bang;

    // start-state handling of the current byte
    logic                 st_emit;
    result_t              st_res;
    logic [2:0]           st_state;
    logic                 st_comment;

    result_t              r0, r1;
    logic [1:0]           n;

    assign s         = (scan_state_reg > ST_T2_DIG) ? ST_START : scan_state_reg;
    assign cls       = class_of(in_char);
    assign nxt_tok   = move(s, cls);
    assign nxt_start = move(ST_START, cls);
    assign is_nl     = (in_char == CH_NEWLINE);
    assign is_bang   = (in_char == CH_BANG);
    assign line_inc  = (line_count_reg == LINE_MAX) ? line_count_reg : line_count_reg + 1'b1;
    assign line_out  = 16'(line_count_reg);

    always_comb begin
        st_emit    = 1'b0;
        st_state   = ST_START;
        st_comment = 1'b0;
        st_res     = '0;
        st_res.line = line_out;
        st_res.out_char = in_char;
        if (is_bang) begin
            st_comment = 1'b1;
        end else if (cls != CLS_WS) begin
            st_emit = 1'b1;
            if (nxt_start == ST_NO_MOVE) begin
                st_res.kind = KIND_ERROR;
            end else begin
                st_res.kind = KIND_CHAR;
                st_state    = nxt_start;
            end
        end
    end

    always_comb begin
        r0              = '0;
        r1              = '0;
        n               = 2'd0;
        scan_state_next = s;
        in_comment_next = in_comment_reg;
        line_count_next = line_count_reg;
        if (end_of_input) begin
            r0.line = line_out;
            r1.line = line_out;
            if (!in_comment_reg && s != ST_START) begin
                r0.kind        = KIND_END;
                r0.token_class = class_of_state(s);
                r1.kind        = KIND_EOF;
                n              = 2'd2;
            end else begin
                r0.kind = KIND_EOF;
                n       = 2'd1;
            end
            scan_state_next = ST_START;
            in_comment_next = 1'b0;
        end else if (in_comment_reg) begin
            if (is_nl) line_count_next = line_inc;
            else if (is_bang) in_comment_next = 1'b0;
        end else if (s == ST_START) begin
            if (is_nl) line_count_next = line_inc;
            r0              = st_res;
            n               = {1'b0, st_emit};
            scan_state_next = st_state;
            in_comment_next = st_comment;
        end else if (nxt_tok != ST_NO_MOVE) begin
            r0.kind         = KIND_CHAR;
            r0.out_char     = in_char;
            r0.line         = line_out;
            n               = 2'd1;
            scan_state_next = nxt_tok;
        end else begin
            // token ends here, the byte is rescanned from the start state
            if (is_nl) line_count_next = line_inc;
            r0.kind         = KIND_END;
            r0.token_class  = class_of_state(s);
            r0.line         = line_out;
            r1              = st_res;
            n               = st_emit ? 2'd2 : 2'd1;
            scan_state_next = st_state;
            in_comment_next = st_comment;
        end
        if (n == 2'd1) r0.last = 1'b1;
        if (n == 2'd2) r1.last = 1'b1;
        if (!item_valid) n = 2'd0;
    end

    assign step_out.count = n;
    assign step_out.r0    = r0;
    assign step_out.r1    = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_state_reg <= ST_START;
            in_comment_reg <= 1'b0;
            line_count_reg <= clamp_line(16'd1);
        end else if (line_load) begin
            line_count_reg <= clamp_line(line_load_value);
        end else if (consume) begin
            scan_state_reg <= scan_state_next;
            in_comment_reg <= in_comment_next;
            line_count_reg <= line_count_next;
        end
    end

    a_comment_in_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_comment_reg |-> scan_state_reg == ST_START)
        else $error("comment open outside start state");

    a_eoi_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && end_of_input && !line_load |=> scan_state_reg == ST_START && !in_comment_reg)
        else $error("end of input did not return to start state");

    a_line_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && !line_load |=> line_count_reg >= $past(line_count_reg))
        else $error("line count went backwards");

endmodule

[sv/tdts_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdts_out_queue
// Two-entry result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module tdts_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  tdts_pkg::step_out_t push,
    output logic                push_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output tdts_pkg::result_t   out_res
);
    import tdts_pkg::*;

    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       pop;
    logic [1:0] cnt_a;
    result_t    t0, t1;
    logic       do_push;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = q0_reg;
    assign pop       = out_valid && out_ready;
    assign cnt_a     = cnt_reg - {1'b0, pop};
    assign push_ok   = ({1'b0, push.count} + {1'b0, cnt_a}) <= 3'd2;
    assign do_push   = push_ok && (push.count != 2'd0);

    always_comb begin
        t0 = pop ? q1_reg : q0_reg;
        t1 = q1_reg;
        q0_next  = t0;
        q1_next  = t1;
        cnt_next = cnt_a;
        if (do_push) begin
            cnt_next = cnt_a + push.count;
            case (cnt_a)
                2'd0: begin
                    q0_next = push.r0;
                    q1_next = push.r1;
                end
                2'd1: begin
                    q1_next = push.r0;
                end
                default: begin
                    q0_next = t0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2)
        else $error("result queue overfilled");

    a_pair_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && push.count == 2'd2 |-> cnt_a == 2'd0)
        else $error("result pair pushed into occupied queue");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && out_res == $past(out_res))
        else $error("stalled result changed");

endmodule
